>>> rtl/dsc_pkg.sv
// shared types and constants for the divisible substring counter
// no dependencies; imported by dsc_mod and the top level of the block
`default_nettype none

package dsc_pkg;

    // fixed field widths
    localparam int MODULUS_W = 12;
    localparam int DIGIT_W   = 4;
    localparam int COUNT_W   = 32;

    localparam logic [MODULUS_W-1:0] MODULUS_RESET = 12'd2019;
    localparam logic [DIGIT_W-1:0]   TEN           = 4'd10;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

    // histogram entries carry a string tag, stale tags read as cleared
    localparam int                 EPOCH_W    = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    // a value below sixteen times the modulus reduces in four subtract steps
    localparam int SUM_STEPS = 4;

    typedef struct packed {
        logic busy;
        logic done;
    } dsc_mod_stat_t;

endpackage

`default_nettype wire

>>> rtl/dsc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/dsc_mod.sv
// iterative modulo reduction: restoring subtract, one quotient bit per cycle
// depends on dsc_pkg for the status struct
`default_nettype none

module dsc_mod
    import dsc_pkg::*;
#(
    parameter int XW = 15,
    parameter int DW = 22,
    parameter int RW = 11,
    parameter int KW = 4
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [XW-1:0] x_in,
    input  wire logic [DW-1:0] dv_in,   // modulus already shifted left by cnt_in
    input  wire logic [KW-1:0] cnt_in,  // number of steps minus one
    output dsc_mod_stat_t      stat,
    output logic      [RW-1:0] result
);

    localparam int CW = (DW > XW) ? DW : XW;

    logic [XW-1:0] x_reg,    x_next;
    logic [DW-1:0] dv_reg,   dv_next;
    logic [KW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          fits;

    // compare at a common width
    assign fits = CW'(x_reg) >= CW'(dv_reg);

    always_comb
    begin
        x_next    = x_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            x_next    = x_in;
            dv_next   = dv_in;
            cnt_next  = cnt_in;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                x_next = x_reg - XW'(dv_reg);
            end
            dv_next = dv_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            dv_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            dv_reg   <= dv_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = x_reg[RW-1:0];

endmodule

`default_nettype wire

>>> rtl/divisible_substring_counter_top.sv
// top level of the divisible substring counter: sequencer, residue state, output register
// depends on dsc_pkg, dsc_ram (residue histogram) and dsc_mod (modulo reduction unit)
`default_nettype none

// Counts substrings of a decimal string divisible by a configured modulus. Digits arrive
// last digit first, one per input word, with final_digit set on the string's first digit;
// each input word gives one output word carrying the running count of equal suffix residue
// pairs (the divisible substring count when the modulus is coprime to ten), saturating at
// all ones, and is_last on the answer for the whole string. A modulus of zero acts as one,
// one above RESIDUE_SLOTS acts as RESIDUE_SLOTS; write it only while the block is idle.
// A digit goes through two passes of the shared four-step modulo unit (new suffix residue,
// then next power of ten) with the histogram read-modify-write hidden under the second
// pass, and the next digit is taken in the cycle after its result at the earliest, so one
// digit is worked on at a time. The first digit after reset or a modulus write, and every
// first digit while the modulus acts as one, first has the held suffix and then the held
// power residue reduced. The histogram lives in one RESIDUE_SLOTS deep ram with a string
// tag per entry; after reset and after every 256th string a clearing pass over every slot
// runs, during which no digit is taken.
// A finished result waits in the output register while the next digit is already worked on.

module divisible_substring_counter_top
    import dsc_pkg::*;
#(
    parameter int RESIDUE_SLOTS = 2048,
    parameter int MAX_DIGITS    = 65536
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // modulus register write
    input  wire logic                 cfg_we,
    input  wire logic [MODULUS_W-1:0] cfg_wdata,
    // digit words
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [DIGIT_W-1:0]   digit,
    input  wire logic                 final_digit,
    // count words
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [COUNT_W-1:0]   pair_count,
    output logic                      is_last
);

    localparam int RW     = $clog2(RESIDUE_SLOTS);      // residue width
    localparam int MW     = $clog2(RESIDUE_SLOTS + 1);  // effective modulus width
    localparam int HW     = $clog2(MAX_DIGITS + 2);     // histogram count width
    localparam int XW     = RW + 4;                     // reduction operand width
    localparam int DW     = MW + RW - 1;                // shifted modulus width
    localparam int KW     = $clog2(RW);                 // step counter width
    localparam int WORD_W = EPOCH_W + HW;

    localparam logic [RW-1:0] SLOT_MASK = RW'(RESIDUE_SLOTS - 1);
    localparam logic [HW-1:0] HIST_CAP  = HW'(MAX_DIGITS + 1);
    localparam logic [KW-1:0] K_STORED  = KW'(RW - 1);
    localparam logic [KW-1:0] K_SUM     = KW'(SUM_STEPS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,    // sweeping the histogram
        ST_IDLE,     // waiting for a digit
        ST_RED_S,    // reducing the held suffix residue
        ST_RED_P,    // reducing the held power residue
        ST_RED_SUM,  // new suffix residue
        ST_RED_POW   // next power of ten, histogram update
    } state_t;

    state_t                 state_reg,    state_next;
    logic [MODULUS_W-1:0]   modulus_reg,  modulus_next;
    logic [RW-1:0]          s_reg,        s_next;
    logic [RW-1:0]          p_reg,        p_next;
    logic [COUNT_W-1:0]     count_reg,    count_next;
    logic                   ok_reg,       ok_next;       // held residues already below modulus
    logic [EPOCH_W-1:0]     epoch_reg,    epoch_next;
    logic [RW-1:0]          clr_addr_reg, clr_addr_next;
    logic [DIGIT_W-1:0]     digit_reg,    digit_next;
    logic                   last_reg,     last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     pair_count_reg, pair_count_next;
    logic                   is_last_reg,  is_last_next;

    logic [MW-1:0]          m_eff;
    logic [DW-1:0]          dv_stored;
    logic [DW-1:0]          dv_sum;
    logic [DIGIT_W-1:0]     sum_d;
    logic [RW-1:0]          sum_p;
    logic [XW-1:0]          sum_x;
    logic [XW-1:0]          pow_x;

    logic                   mod_start;
    logic [XW-1:0]          mod_x;
    logic [DW-1:0]          mod_dv;
    logic [KW-1:0]          mod_cnt;
    dsc_mod_stat_t          mod_stat;
    logic [RW-1:0]          mod_res;

    logic                   mem_we;
    logic                   mem_re;
    logic [RW-1:0]          mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;
    logic [WORD_W-1:0]      mem_rdata;

    logic [RW-1:0]          slot_addr;
    logic [HW-1:0]          hist_val;
    logic [HW-1:0]          hist_inc;
    logic [HW-1:0]          clr_val;
    logic [COUNT_W:0]       sum_wide;
    logic [COUNT_W-1:0]     count_sat;
    logic                   finish;

    // modulus zero acts as one, oversize clamps to the number of slots
    always_comb
    begin
        if (modulus_reg == '0)
        begin
            m_eff = MW'(1);
        end
        else if (int'(modulus_reg) > RESIDUE_SLOTS)
        begin
            m_eff = MW'(RESIDUE_SLOTS);
        end
        else
        begin
            m_eff = MW'(modulus_reg);
        end
    end

    assign dv_stored = DW'(m_eff) << (RW - 1);
    assign dv_sum    = DW'(m_eff) << (SUM_STEPS - 1);

    // s + d * p with s and p below the modulus stays under sixteen moduli
    assign sum_d = (state_reg == ST_IDLE)  ? digit   : digit_reg;
    assign sum_p = (state_reg == ST_RED_P) ? mod_res : p_reg;
    assign sum_x = XW'(s_reg) + XW'(sum_d) * XW'(sum_p);
    assign pow_x = XW'(p_reg) * XW'(TEN);

    // histogram word: tag of the string that wrote it, then the count
    assign slot_addr = s_reg & SLOT_MASK;
    assign hist_val  = (mem_rdata[WORD_W-1:HW] == epoch_reg) ? mem_rdata[HW-1:0]
                     : ((slot_addr == '0) ? HW'(1) : '0);
    assign hist_inc  = (hist_val < HIST_CAP) ? hist_val + HW'(1) : hist_val;
    assign clr_val   = (clr_addr_reg == '0) ? HW'(1) : '0;

    // saturating running count
    assign sum_wide  = {1'b0, count_reg} + (COUNT_W + 1)'(hist_val);
    assign count_sat = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];

    // last step of a digit, held back while the output register is still full
    assign finish = (state_reg == ST_RED_POW) && mod_stat.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        modulus_next    = modulus_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        count_next      = count_reg;
        ok_next         = ok_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        digit_next      = digit_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        pair_count_next = pair_count_reg;
        is_last_next    = is_last_reg;

        mod_start = 1'b0;
        mod_x     = XW'(s_reg);
        mod_dv    = dv_stored;
        mod_cnt   = K_STORED;

        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot_addr;
        mem_wdata = {epoch_reg, hist_inc};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = {epoch_reg, clr_val};
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_MASK)
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    digit_next = digit;
                    last_next  = final_digit;
                    mod_start  = 1'b1;
                    if (ok_reg)
                    begin
                        mod_x      = sum_x;
                        mod_dv     = dv_sum;
                        mod_cnt    = K_SUM;
                        state_next = ST_RED_SUM;
                    end
                    else
                    begin
                        state_next = ST_RED_S;
                    end
                end
            end
            ST_RED_S:
            begin
                if (mod_stat.done)
                begin
                    s_next     = mod_res;
                    mod_start  = 1'b1;
                    mod_x      = XW'(p_reg);
                    state_next = ST_RED_P;
                end
            end
            ST_RED_P:
            begin
                if (mod_stat.done)
                begin
                    p_next     = mod_res;
                    mod_start  = 1'b1;
                    mod_x      = sum_x;
                    mod_dv     = dv_sum;
                    mod_cnt    = K_SUM;
                    state_next = ST_RED_SUM;
                end
            end
            ST_RED_SUM:
            begin
                if (mod_stat.done)
                begin
                    // histogram read overlaps the power reduction
                    s_next     = mod_res;
                    mem_re     = 1'b1;
                    mod_start  = 1'b1;
                    mod_x      = pow_x;
                    mod_dv     = dv_sum;
                    mod_cnt    = K_SUM;
                    state_next = ST_RED_POW;
                end
            end
            ST_RED_POW:
            begin
                if (finish)
                begin
                    mem_we          = 1'b1;
                    count_next      = count_sat;
                    p_next          = mod_res;
                    ok_next         = 1'b1;
                    out_valid_next  = 1'b1;
                    pair_count_next = count_sat;
                    is_last_next    = last_reg;
                    state_next      = ST_IDLE;
                    if (last_reg)
                    begin
                        // new string: fresh residues, new tag, sweep when tags wrap
                        s_next     = '0;
                        p_next     = RW'(1);
                        count_next = '0;
                        ok_next    = (m_eff != MW'(1));
                        epoch_next = epoch_reg + 1'b1;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            state_next = ST_CLEAR;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_we)
        begin
            modulus_next = cfg_wdata;
            ok_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            modulus_reg    <= MODULUS_RESET;
            s_reg          <= '0;
            p_reg          <= RW'(1);
            count_reg      <= '0;
            ok_reg         <= 1'b0;
            epoch_reg      <= '0;
            clr_addr_reg   <= '0;
            digit_reg      <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pair_count_reg <= '0;
            is_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            modulus_reg    <= modulus_next;
            s_reg          <= s_next;
            p_reg          <= p_next;
            count_reg      <= count_next;
            ok_reg         <= ok_next;
            epoch_reg      <= epoch_next;
            clr_addr_reg   <= clr_addr_next;
            digit_reg      <= digit_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            pair_count_reg <= pair_count_next;
            is_last_reg    <= is_last_next;
        end
    end

    dsc_mod #(
        .XW (XW),
        .DW (DW),
        .RW (RW),
        .KW (KW)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .x_in   (mod_x),
        .dv_in  (mod_dv),
        .cnt_in (mod_cnt),
        .stat   (mod_stat),
        .result (mod_res)
    );

    // residue histogram
    dsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RESIDUE_SLOTS)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mod_res & SLOT_MASK),
        .rdata (mem_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign pair_count = pair_count_reg;
    assign is_last    = is_last_reg;

`ifndef SYNTH
    // residues flagged as reduced really are below the modulus
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ok_reg |-> (MW'(s_reg) < m_eff) && (MW'(p_reg) < m_eff))
        else $error("held residue not below modulus");

    // reduction unit is quiet whenever no digit is in flight
    a_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_CLEAR) |-> !mod_stat.busy)
        else $error("reduction unit busy with no digit in flight");

    // the running count only falls at a string boundary
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(finish && last_reg) |-> count_reg >= $past(count_reg))
        else $error("running count fell inside a string");

    // histogram read and write never share a cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("histogram read and write in the same cycle");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for divisible_substring_counter_top
// depends on dsc_pkg and the rtl of the block; needs no other file

module tb
    import dsc_pkg::*;
();

    localparam int RESIDUE_SLOTS = 2048;
    localparam int MAX_DIGITS    = 65536;

    // a histogram entry stops growing here
    localparam int unsigned HIST_CAP = MAX_DIGITS + 1;

    // quiet time before a modulus write: covers a clearing pass plus the residue reduction
    localparam int SETTLE_CYCLES = RESIDUE_SLOTS + 64;
    // quiet time after the last count word, to catch stray words
    localparam int TAIL_CYCLES   = 64;
    // cycles without any word moving before the run is abandoned
    localparam int WATCHDOG_LIMIT = 10000;

    localparam int SHORT_STRINGS = 300;
    localparam int RANDOM_ITEMS  = 650;
    localparam int MAX_REPORTS   = 50;

    // one expected count word
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               last;
    } count_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [MODULUS_W-1:0] cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [DIGIT_W-1:0]   digit = '0;
    logic                 final_digit = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COUNT_W-1:0]   pair_count;
    logic                 is_last;

    // predictor state, mirrors the block's string state
    logic [MODULUS_W-1:0] modulus_reg;
    int unsigned          suffix_res;
    int unsigned          power_res;
    int unsigned          res_hist [RESIDUE_SLOTS];
    logic [COUNT_W-1:0]   pair_total;

    // count words still owed by the block, oldest first
    count_word_t expected_counts [$];

    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned stall_left    = 0;

    // flags for stretches without idling on either side
    bit in_no_gaps    = 1'b0;
    bit out_no_stalls = 1'b0;

    divisible_substring_counter_top #(
        .RESIDUE_SLOTS (RESIDUE_SLOTS),
        .MAX_DIGITS    (MAX_DIGITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .digit       (digit),
        .final_digit (final_digit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pair_count  (pair_count),
        .is_last     (is_last)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to the empty string: only the empty suffix, residue zero
    function automatic void clear_string_state();
        suffix_res = 0;
        power_res  = 1;
        foreach (res_hist[i])
            res_hist[i] = 0;
        res_hist[0] = 1;
        pair_total  = '0;
    endfunction

    // works out the count word for one accepted digit and advances the state
    function automatic count_word_t predict_pair_count(logic [DIGIT_W-1:0] d, logic fin);
        int unsigned       m;
        int unsigned       r;
        int unsigned       h;
        longint unsigned   sum;
        count_word_t       w;
        // zero acts as one, anything above the slot count is clamped
        m = 32'(modulus_reg);
        if (m == 0)
            m = 1;
        if (m > RESIDUE_SLOTS)
            m = RESIDUE_SLOTS;
        // held residues may come from an older modulus, so reduce them first
        r = (suffix_res % m + 32'(d) * (power_res % m)) % m;
        suffix_res = r;
        power_res  = ((power_res % m) * 10) % m;
        r = r & (RESIDUE_SLOTS - 1);
        h = res_hist[r];
        // each new residue pairs with every earlier equal one; saturating
        sum = longint'(pair_total) + longint'(h);
        if (sum > 64'hFFFF_FFFF)
            pair_total = '1;
        else
            pair_total = sum[COUNT_W-1:0];
        if (h < HIST_CAP)
            res_hist[r] = h + 1;
        w.count = pair_total;
        w.last  = fin;
        if (fin)
            clear_string_state();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap(bit no_gaps);
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // decimal digits mostly, the odd out-of-range nibble
    function automatic logic [DIGIT_W-1:0] random_digit();
        if ($urandom_range(0, 99) < 85)
            return DIGIT_W'($urandom_range(0, 9));
        return DIGIT_W'($urandom_range(10, 15));
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 16);
        if (r < 97)
            return $urandom_range(17, 60);
        return $urandom_range(61, 200);
    endfunction

    // small moduli give many equal residues, the rest spread over the field
    function automatic logic [MODULUS_W-1:0] pick_modulus();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return MODULUS_W'($urandom_range(1, 40));
        if (r < 55)
        begin
            case ($urandom_range(0, 5))
                0:       return 12'd0;
                1:       return 12'd1;
                2:       return 12'd2047;
                3:       return 12'd2048;
                4:       return 12'd2049;
                default: return 12'd4095;
            endcase
        end
        if (r < 75)
            return MODULUS_W'($urandom_range(1, RESIDUE_SLOTS));
        return MODULUS_W'($urandom_range(0, 4095));
    endfunction

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // offers one digit word and returns at the edge that takes it; valid is left
    // high so a following word can go out back to back
    task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic fin);
        int unsigned gap;
        gap = pick_gap(in_no_gaps);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        digit       <= d;
        final_digit <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_counts.push_back(predict_pair_count(d, fin));
    endtask

    // modulus writes happen only with the block drained and settled
    task automatic write_modulus(input logic [MODULUS_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        modulus_reg = value;
    endtask

    // ------------------------------------------------------------------
    // checking side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch on count word %0d: %s got %0d expected %0d",
                     words_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_count_word();
        count_word_t want;
        if (expected_counts.size() == 0)
        begin
            report_mismatch("unexpected word, pair_count", 64'(pair_count), 64'(0));
        end
        else
        begin
            want = expected_counts.pop_front();
            if (pair_count !== want.count)
                report_mismatch("pair_count", 64'(pair_count), 64'(want.count));
            if (is_last !== want.last)
                report_mismatch("is_last", 64'(is_last), 64'(want.last));
        end
        words_checked++;
    endtask

    // output handshake: compare each taken word, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            check_count_word();
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (pick_gap(out_no_stalls) == 0)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap(1'b0);
        end
    end

    // watchdog: any word moving, either side or the modulus port, restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset modulus 2019: the string "2019" itself, then a lone zero
    task automatic test_reset_modulus();
        send_digit(4'd9, 1'b0);
        send_digit(4'd1, 1'b0);
        send_digit(4'd0, 1'b0);
        send_digit(4'd2, 1'b1);
        send_digit(4'd0, 1'b1);
    endtask

    // zero acts as one, 4095 clamps to the slot count, ten shares factors with the base;
    // digits cover all-zero, all-one and out-of-range nibbles
    task automatic test_modulus_extremes();
        logic [MODULUS_W-1:0] moduli [7];
        moduli = '{12'd0, 12'd1, 12'd2048, 12'd4095, 12'd2047, 12'd10, 12'd3};
        foreach (moduli[i])
        begin
            write_modulus(moduli[i]);
            send_digit(4'd15, 1'b0);
            send_digit((i % 2) ? 4'd10 : 4'd0, 1'b1);
        end
    endtask

    // modulus changed part-way through a string: held residues get reduced on next use
    task automatic test_midstring_modulus();
        write_modulus(12'd2048);
        send_digit(4'd4, 1'b0);
        send_digit(4'd9, 1'b0);
        send_digit(4'd8, 1'b0);
        write_modulus(12'd3);
        send_digit(4'd7, 1'b0);
        send_digit(4'd1, 1'b0);
        send_digit(4'd6, 1'b1);
    endtask

    // many tiny strings, so the string tags wrap and a clearing pass runs mid-traffic
    task automatic test_many_short_strings();
        int unsigned len;
        write_modulus(MODULUS_W'($urandom_range(2, 12)));
        for (int s = 0; s < SHORT_STRINGS; s++)
        begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
                send_digit(random_digit(), i == len - 1);
        end
    endtask

    // phases of random strings, each under its own modulus and idling pattern;
    // now and then a phase ends with its string still open
    task automatic test_random_strings();
        int unsigned sent;
        int unsigned budget;
        int unsigned done_here;
        int unsigned len;
        bit          open_end;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_modulus(pick_modulus());
            in_no_gaps    = ($urandom_range(0, 3) == 0);
            out_no_stalls = ($urandom_range(0, 3) == 0);
            budget    = $urandom_range(40, 120);
            done_here = 0;
            while (done_here < budget)
            begin
                len      = pick_length();
                open_end = (done_here + len >= budget) && ($urandom_range(0, 5) == 0);
                for (int i = 0; i < len; i++)
                    send_digit(random_digit(), (i == len - 1) && !open_end);
                done_here += len;
            end
            sent += done_here;
        end
        in_no_gaps    = 1'b0;
        out_no_stalls = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        modulus_reg = MODULUS_RESET;
        clear_string_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_modulus();
        test_modulus_extremes();
        test_midstring_modulus();
        test_many_short_strings();
        test_random_strings();

        // drain, then give stray words a chance to show up
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
